// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held low
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/u8dnc_pkg.sv =====
// Package: types and constants shared by the UTF-8 display name checker
package u8dnc_pkg;

    // Name length in bytes at which a name is cut off and reported invalid
    localparam int unsigned MAX_NAME_BYTES = 64;
    localparam int unsigned LEN_W          = 7;
    localparam int unsigned CP_W           = 21;

    // Byte classes
    localparam logic [7:0] BYTE_TERM      = 8'h00;
    localparam logic [7:0] BYTE_CTRL_LIM  = 8'h20;
    localparam logic [7:0] BYTE_DEL       = 8'h7F;
    localparam logic [7:0] BYTE_ASCII_LIM = 8'h80;
    localparam logic [7:0] LEAD2_LO       = 8'hC2;
    localparam logic [7:0] LEAD2_HI       = 8'hDF;
    localparam logic [7:0] LEAD3_LO       = 8'hE0;
    localparam logic [7:0] LEAD3_HI       = 8'hEF;
    localparam logic [7:0] LEAD4_LO       = 8'hF0;
    localparam logic [7:0] LEAD4_HI       = 8'hF4;
    localparam logic [1:0] CONT_TAG       = 2'b10;

    // Continuation counts of the multi-byte forms
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    // Code point limits
    localparam logic [CP_W-1:0] CP_MIN3     = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4     = 21'h010000;
    localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;

    // One verdict word
    typedef struct packed {
        logic             name_valid;
        logic [LEN_W-1:0] name_length;
    } t_result;

endpackage

// ===== src/u8dnc_core.sv =====
// Decoder core: per-name state registers and the per-byte UTF-8 checks
module u8dnc_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_byte,
    output logic                o_res_fire,
    output u8dnc_pkg::t_result  o_res
);

    localparam logic [u8dnc_pkg::LEN_W-1:0] MAX_LEN =
        u8dnc_pkg::LEN_W'(u8dnc_pkg::MAX_NAME_BYTES);

    logic [1:0]                    r_pending, n_pending;
    logic [1:0]                    r_seq_size, n_seq_size;
    logic [u8dnc_pkg::CP_W-1:0]    r_acc, n_acc;
    logic [u8dnc_pkg::LEN_W-1:0]   r_count, n_count;
    logic                          r_failed, n_failed;
    logic                          r_skip, n_skip;

    // Next state and verdict for the byte at hand
    always_comb begin
        logic [u8dnc_pkg::LEN_W-1:0] cnt_inc;
        logic [u8dnc_pkg::CP_W-1:0]  cp;
        n_pending  = r_pending;
        n_seq_size = r_seq_size;
        n_acc      = r_acc;
        n_count    = r_count;
        n_failed   = r_failed;
        n_skip     = r_skip;
        o_res_fire = 1'b0;
        o_res      = '0;
        cnt_inc    = r_count + 1'b1;
        cp         = {r_acc[u8dnc_pkg::CP_W-7:0], i_byte[5:0]};

        if (i_fire) begin
            priority if (r_skip) begin
                // dropping the tail of an overlong name
                if (i_byte == u8dnc_pkg::BYTE_TERM) begin
                    n_skip     = 1'b0;
                    n_pending  = u8dnc_pkg::SEQ_NONE;
                    n_seq_size = u8dnc_pkg::SEQ_NONE;
                    n_acc      = '0;
                    n_count    = '0;
                    n_failed   = 1'b0;
                end
            end else if (i_byte == u8dnc_pkg::BYTE_TERM) begin
                // terminator: give the verdict and start afresh
                o_res_fire        = 1'b1;
                o_res.name_valid  = !r_failed && (r_pending == u8dnc_pkg::SEQ_NONE)
                                    && (r_count != '0);
                o_res.name_length = r_count;
                n_pending  = u8dnc_pkg::SEQ_NONE;
                n_seq_size = u8dnc_pkg::SEQ_NONE;
                n_acc      = '0;
                n_count    = '0;
                n_failed   = 1'b0;
            end else begin
                n_count = cnt_inc;
                // decode only while the name still stands
                if (!r_failed) begin
                    if (r_pending == u8dnc_pkg::SEQ_NONE) begin
                        priority if (i_byte < u8dnc_pkg::BYTE_CTRL_LIM ||
                                     i_byte == u8dnc_pkg::BYTE_DEL) begin
                            n_failed = 1'b1;
                        end else if (i_byte < u8dnc_pkg::BYTE_ASCII_LIM) begin
                            n_failed = r_failed;
                        end else if (i_byte >= u8dnc_pkg::LEAD2_LO &&
                                     i_byte <= u8dnc_pkg::LEAD2_HI) begin
                            n_pending  = u8dnc_pkg::SEQ_TWO;
                            n_seq_size = u8dnc_pkg::SEQ_TWO;
                            n_acc      = {16'd0, i_byte[4:0]};
                        end else if (i_byte >= u8dnc_pkg::LEAD3_LO &&
                                     i_byte <= u8dnc_pkg::LEAD3_HI) begin
                            n_pending  = u8dnc_pkg::SEQ_THREE;
                            n_seq_size = u8dnc_pkg::SEQ_THREE;
                            n_acc      = {17'd0, i_byte[3:0]};
                        end else if (i_byte >= u8dnc_pkg::LEAD4_LO &&
                                     i_byte <= u8dnc_pkg::LEAD4_HI) begin
                            n_pending  = u8dnc_pkg::SEQ_FOUR;
                            n_seq_size = u8dnc_pkg::SEQ_FOUR;
                            n_acc      = {18'd0, i_byte[2:0]};
                        end else begin
                            n_failed = 1'b1;
                        end
                    end else if (i_byte[7:6] != u8dnc_pkg::CONT_TAG) begin
                        n_failed  = 1'b1;
                        n_pending = u8dnc_pkg::SEQ_NONE;
                    end else begin
                        n_acc     = cp;
                        n_pending = r_pending - 1'b1;
                        // last continuation: range checks on the code point
                        if (r_pending == u8dnc_pkg::SEQ_TWO) begin
                            if ((r_seq_size == u8dnc_pkg::SEQ_THREE &&
                                 cp < u8dnc_pkg::CP_MIN3) ||
                                (r_seq_size == u8dnc_pkg::SEQ_FOUR &&
                                 cp < u8dnc_pkg::CP_MIN4) ||
                                (cp >= u8dnc_pkg::CP_SURR_LO &&
                                 cp <= u8dnc_pkg::CP_SURR_HI) ||
                                cp > u8dnc_pkg::CP_MAX) begin
                                n_failed = 1'b1;
                            end
                        end
                    end
                end
                // length limit reached: report and skip to the terminator
                if (cnt_inc >= MAX_LEN) begin
                    o_res_fire        = 1'b1;
                    o_res.name_valid  = 1'b0;
                    o_res.name_length = MAX_LEN;
                    n_pending  = u8dnc_pkg::SEQ_NONE;
                    n_seq_size = u8dnc_pkg::SEQ_NONE;
                    n_acc      = '0;
                    n_count    = '0;
                    n_failed   = 1'b0;
                    n_skip     = 1'b1;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= u8dnc_pkg::SEQ_NONE;
            r_seq_size <= u8dnc_pkg::SEQ_NONE;
            r_acc      <= '0;
            r_count    <= '0;
            r_failed   <= 1'b0;
            r_skip     <= 1'b0;
        end else begin
            r_pending  <= n_pending;
            r_seq_size <= n_seq_size;
            r_acc      <= n_acc;
            r_count    <= n_count;
            r_failed   <= n_failed;
            r_skip     <= n_skip;
        end
    end

endmodule

// ===== src/u8dnc_out_reg.sv =====
// Result register holding one verdict word until the receiver takes it
module u8dnc_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  u8dnc_pkg::t_result  i_res,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output u8dnc_pkg::t_result  o_res
);

    logic               r_valid, n_valid;
    u8dnc_pkg::t_result r_res;

    // Full when loaded, empty once taken
    always_comb begin
        n_valid = r_valid;
        priority if (i_load)               n_valid = 1'b1;
        else if (r_valid && i_out_ready)   n_valid = 1'b0;
        else                               n_valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

// ===== src/utf8_display_name_checker.sv =====
// Top level: input register, decoder core and result register
//
// Checks NUL-terminated names, one byte per input word, for well-formed UTF-8
// with no control characters, and gives one verdict word per name.
// Input channel: i_in_valid / o_in_ready with i_name_byte; a zero byte ends
// the name. Output channel: o_out_valid / i_out_ready with o_name_valid and
// o_name_length.
// A verdict is loaded into the result register as its terminating byte (or
// the byte that reaches the length limit) leaves the input register.
// Throughput: one byte per cycle while no verdict waits on a stalled receiver;
// each byte passes the input register and is decoded against per-name state.
// A name reaching MAX_NAME_BYTES bytes is reported invalid at that length and
// the rest up to the next zero byte is dropped without a verdict.
// Reset (synchronous, active low) empties both registers and clears the
// per-name state, so the next byte starts a new name.
// While a verdict waits on a stalled receiver no byte is decoded: the byte in
// the input register holds, one more is taken only into an empty input
// register, and o_in_ready then follows i_out_ready.
module utf8_display_name_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_name_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_name_valid,
    output logic [u8dnc_pkg::LEN_W-1:0]       o_name_length
);

    logic               r_in_valid, n_in_valid;
    logic [7:0]         r_in_byte;
    logic               can_fire;
    logic               core_fire;
    logic               res_fire;
    logic               out_valid;
    u8dnc_pkg::t_result core_res;
    u8dnc_pkg::t_result out_res;
    logic               in_accept;

    // A held byte can move on when the result register is free or draining
    assign can_fire  = !out_valid || i_out_ready;
    assign core_fire = r_in_valid && can_fire;
    assign o_in_ready = !r_in_valid || can_fire;
    assign in_accept = i_in_valid && o_in_ready;

    // Input register
    always_comb begin
        n_in_valid = r_in_valid;
        priority if (in_accept)  n_in_valid = 1'b1;
        else if (core_fire)      n_in_valid = 1'b0;
        else                     n_in_valid = r_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_name_byte;
        end
    end

    u8dnc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (core_fire),
        .i_byte     (r_in_byte),
        .o_res_fire (res_fire),
        .o_res      (core_res)
    );

    u8dnc_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_fire),
        .i_res       (core_res),
        .i_out_ready (i_out_ready),
        .o_out_valid (out_valid),
        .o_res       (out_res)
    );

    assign o_out_valid   = out_valid;
    assign o_name_valid  = out_res.name_valid;
    assign o_name_length = out_res.name_length;

endmodule

// ===== src/u8dnc_checker.sv =====
// Port-level checker for the UTF-8 display name checker, bound to the top level
`include "assert_macros.svh"

module u8dnc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic                        o_name_valid,
    input  logic [u8dnc_pkg::LEN_W-1:0] o_name_length
);

    localparam logic [u8dnc_pkg::LEN_W-1:0] MAX_LEN =
        u8dnc_pkg::LEN_W'(u8dnc_pkg::MAX_NAME_BYTES);

    // A stalled verdict word holds
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_name_valid) && $stable(o_name_length))
    // Empty result register never blocks the input side
    `CHK_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    // A passing name is non-empty and shorter than the limit
    `CHK_SAME(a_valid_len, i_clk, i_rst_n, o_out_valid && o_name_valid, o_name_length != '0 && o_name_length < MAX_LEN)
    // Reported length never exceeds the limit
    `CHK_SAME(a_len_cap, i_clk, i_rst_n, o_out_valid, o_name_length <= MAX_LEN)

endmodule

bind utf8_display_name_checker u8dnc_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_name_valid  (o_name_valid),
    .o_name_length (o_name_length)
);
